/* rtl/blsp_pkg.sv */
// Package for the Bresenham line stepper: widths, word layouts and the
// line setup record shared by the setup logic, the stepper core and the top.
// No dependencies.
package blsp_pkg;

    localparam int COORD_BITS = 12;
    localparam int DIFF_BITS  = COORD_BITS + 1;
    localparam int ERR_BITS   = COORD_BITS + 3;

    localparam int IN_DATA_BITS  = ((4 * COORD_BITS + 7) / 8) * 8;
    localparam int OUT_DATA_BITS = ((2 * COORD_BITS + 7) / 8) * 8;

    typedef logic [COORD_BITS-1:0]      coord_t;
    typedef logic signed [ERR_BITS-1:0] err_t;

    // tuser codes on the input side
    typedef enum logic
    {
        ACT_LOAD = 1'b0,
        ACT_STEP = 1'b1
    } action_t;

    // Normalized line, ready to load into the stepper state
    typedef struct packed
    {
        logic   steep;
        coord_t major_start;
        coord_t major_end;
        coord_t minor_start;
        logic   minor_down;
        err_t   err_init;
        err_t   inc_straight;
        err_t   inc_diagonal;
    } blsp_line_t;

endpackage

/* rtl/bresenham_line_stepper_top.sv */
// Top level of the Bresenham line stepper: stream ports, input word register,
// setup logic and stepper core. Depends on blsp_pkg, blsp_setup, blsp_core.
//
//  channel | dir | handshake          | payload
//  --------+-----+--------------------+---------------------------------------------
//  s_*     | in  | s_tvalid/s_tready  | s_tuser = action, s_tdata = endpoints
//  m_*     | out | m_tvalid/m_tready  | m_tdata = pixel x,y, m_tlast = last_pixel
//
// One word per cycle sustained on the input while results are taken; only a step
// word on an active line yields a pixel. In the input register, load setup (span,
// octant swap, error terms) is done combinationally into the line state; a step
// word that advances writes its pixel into the result register, driving m_tvalid.
// Reset (rst_n low) drops any line in progress and empties both registers.
// A stall on m_tready holds the result; the input register then fills and
// s_tready falls until the result is taken.
module bresenham_line_stepper_top
(
    input  logic                                 clk,
    input  logic                                 rst_n,
    input  logic                                 s_tvalid,
    output logic                                 s_tready,
    // start_x, start_y, end_x, end_y (lowest bits first), zero padded
    input  logic [blsp_pkg::IN_DATA_BITS-1:0]    s_tdata,
    // action: 0 load endpoints, 1 next pixel
    input  logic                                 s_tuser,
    output logic                                 m_tvalid,
    input  logic                                 m_tready,
    // pixel_x, pixel_y (lowest bits first), zero padded
    output logic [blsp_pkg::OUT_DATA_BITS-1:0]   m_tdata,
    // last_pixel
    output logic                                 m_tlast
);
    import blsp_pkg::*;

    logic       in_vld_reg, in_vld_next;
    action_t    in_act_reg;
    coord_t     in_sx_reg;
    coord_t     in_sy_reg;
    coord_t     in_ex_reg;
    coord_t     in_ey_reg;
    logic       s_fire;
    logic       advance;
    blsp_line_t line;
    coord_t     res_x;
    coord_t     res_y;

    // input register frees up whenever its word moves on
    assign s_tready    = !in_vld_reg || advance;
    assign s_fire      = s_tvalid && s_tready;
    assign in_vld_next = s_fire || (in_vld_reg && !advance);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_vld_reg <= 1'b0;
        end
        else
        begin
            in_vld_reg <= in_vld_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (s_fire)
        begin
            in_act_reg <= action_t'(s_tuser);
            in_sx_reg  <= s_tdata[COORD_BITS-1:0];
            in_sy_reg  <= s_tdata[2*COORD_BITS-1:COORD_BITS];
            in_ex_reg  <= s_tdata[3*COORD_BITS-1:2*COORD_BITS];
            in_ey_reg  <= s_tdata[4*COORD_BITS-1:3*COORD_BITS];
        end
    end

    blsp_setup u_setup
    (
        .start_x (in_sx_reg),
        .start_y (in_sy_reg),
        .end_x   (in_ex_reg),
        .end_y   (in_ey_reg),
        .line    (line)
    );

    blsp_core u_core
    (
        .clk         (clk),
        .rst_n       (rst_n),
        .item_vld    (in_vld_reg),
        .item_action (in_act_reg),
        .item_line   (line),
        .advance     (advance),
        .res_vld     (m_tvalid),
        .res_rdy     (m_tready),
        .res_x       (res_x),
        .res_y       (res_y),
        .res_last    (m_tlast)
    );

    assign m_tdata = OUT_DATA_BITS'({res_y, res_x});

endmodule

/* rtl/blsp_setup.sv */
// Line setup: octant normalization and midpoint error terms for one load word.
// Purely combinational; depends on blsp_pkg.
module blsp_setup
(
    input  blsp_pkg::coord_t     start_x,
    input  blsp_pkg::coord_t     start_y,
    input  blsp_pkg::coord_t     end_x,
    input  blsp_pkg::coord_t     end_y,
    output blsp_pkg::blsp_line_t line
);
    import blsp_pkg::*;

    logic signed [DIFF_BITS-1:0] dx;
    logic signed [DIFF_BITS-1:0] dy;
    coord_t                      adx;
    coord_t                      ady;
    logic                        steep;
    logic signed [DIFF_BITS-1:0] dmaj_s;
    logic signed [DIFF_BITS-1:0] dmin_s;
    logic                        swap_ends;
    coord_t                      dmaj;
    coord_t                      dmin;
    err_t                        dmaj_e;
    err_t                        dmin2_e;

    always_comb
    begin
        dx  = $signed({1'b0, end_x}) - $signed({1'b0, start_x});
        dy  = $signed({1'b0, end_y}) - $signed({1'b0, start_y});
        adx = dx[DIFF_BITS-1] ? COORD_BITS'(-dx) : dx[COORD_BITS-1:0];
        ady = dy[DIFF_BITS-1] ? COORD_BITS'(-dy) : dy[COORD_BITS-1:0];

        // equal spans stay x-major
        steep  = ady > adx;
        dmaj_s = steep ? dy : dx;
        dmin_s = steep ? dx : dy;

        // run the major axis upward; minor direction flips with the swap
        swap_ends = dmaj_s[DIFF_BITS-1];
        dmaj      = steep ? ady : adx;
        dmin      = steep ? adx : ady;

        line.steep = steep;
        if (swap_ends)
        begin
            line.major_start = steep ? end_y : end_x;
            line.major_end   = steep ? start_y : start_x;
            line.minor_start = steep ? end_x : end_y;
            line.minor_down  = (dmin_s != '0) && !dmin_s[DIFF_BITS-1];
        end
        else
        begin
            line.major_start = steep ? start_y : start_x;
            line.major_end   = steep ? end_y : end_x;
            line.minor_start = steep ? start_x : start_y;
            line.minor_down  = dmin_s[DIFF_BITS-1];
        end

        dmaj_e            = ERR_BITS'(dmaj);
        dmin2_e           = ERR_BITS'({dmin, 1'b0});
        line.err_init     = dmin2_e - dmaj_e;
        line.inc_straight = dmin2_e;
        line.inc_diagonal = dmin2_e - (dmaj_e <<< 1);
    end

endmodule

/* rtl/blsp_core.sv */
// Stepper core: line state registers, per-pixel update and the result register.
// Depends on blsp_pkg; fed by blsp_setup through the top level.
module blsp_core
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 item_vld,
    input  blsp_pkg::action_t    item_action,
    input  blsp_pkg::blsp_line_t item_line,
    output logic                 advance,
    output logic                 res_vld,
    input  logic                 res_rdy,
    output blsp_pkg::coord_t     res_x,
    output blsp_pkg::coord_t     res_y,
    output logic                 res_last
);
    import blsp_pkg::*;

    logic   active_reg,     active_next;
    logic   steep_reg,      steep_next;
    coord_t major_pos_reg,  major_pos_next;
    coord_t major_end_reg,  major_end_next;
    coord_t minor_pos_reg,  minor_pos_next;
    logic   minor_down_reg, minor_down_next;
    err_t   err_reg,        err_next;
    err_t   inc_s_reg,      inc_s_next;
    err_t   inc_d_reg,      inc_d_next;

    logic   out_vld_reg,    out_vld_next;
    coord_t out_x_reg,      out_x_next;
    coord_t out_y_reg,      out_y_next;
    logic   out_last_reg,   out_last_next;

    logic   do_load;
    logic   do_pixel;
    logic   at_end;
    logic   go_straight;

    assign advance  = item_vld && (!out_vld_reg || res_rdy);
    assign do_load  = advance && (item_action == ACT_LOAD);
    assign do_pixel = advance && (item_action == ACT_STEP) && active_reg;
    assign at_end   = major_pos_reg == major_end_reg;
    assign go_straight = err_reg[ERR_BITS-1] || (err_reg == '0);

    always_comb
    begin
        active_next     = active_reg;
        steep_next      = steep_reg;
        major_pos_next  = major_pos_reg;
        major_end_next  = major_end_reg;
        minor_pos_next  = minor_pos_reg;
        minor_down_next = minor_down_reg;
        err_next        = err_reg;
        inc_s_next      = inc_s_reg;
        inc_d_next      = inc_d_reg;
        out_x_next      = out_x_reg;
        out_y_next      = out_y_reg;
        out_last_next   = out_last_reg;
        out_vld_next    = out_vld_reg && !res_rdy;

        if (do_load)
        begin
            active_next     = 1'b1;
            steep_next      = item_line.steep;
            major_pos_next  = item_line.major_start;
            major_end_next  = item_line.major_end;
            minor_pos_next  = item_line.minor_start;
            minor_down_next = item_line.minor_down;
            err_next        = item_line.err_init;
            inc_s_next      = item_line.inc_straight;
            inc_d_next      = item_line.inc_diagonal;
        end
        else if (do_pixel)
        begin
            out_vld_next  = 1'b1;
            out_x_next    = steep_reg ? minor_pos_reg : major_pos_reg;
            out_y_next    = steep_reg ? major_pos_reg : minor_pos_reg;
            out_last_next = at_end;
            if (at_end)
            begin
                active_next = 1'b0;
            end
            else
            begin
                major_pos_next = major_pos_reg + 1'b1;
                if (go_straight)
                begin
                    err_next = err_reg + inc_s_reg;
                end
                else
                begin
                    err_next       = err_reg + inc_d_reg;
                    minor_pos_next = minor_down_reg ? minor_pos_reg - 1'b1
                                                    : minor_pos_reg + 1'b1;
                end
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            active_reg     <= 1'b0;
            steep_reg      <= 1'b0;
            major_pos_reg  <= '0;
            major_end_reg  <= '0;
            minor_pos_reg  <= '0;
            minor_down_reg <= 1'b0;
            err_reg        <= '0;
            inc_s_reg      <= '0;
            inc_d_reg      <= '0;
            out_vld_reg    <= 1'b0;
        end
        else
        begin
            active_reg     <= active_next;
            steep_reg      <= steep_next;
            major_pos_reg  <= major_pos_next;
            major_end_reg  <= major_end_next;
            minor_pos_reg  <= minor_pos_next;
            minor_down_reg <= minor_down_next;
            err_reg        <= err_next;
            inc_s_reg      <= inc_s_next;
            inc_d_reg      <= inc_d_next;
            out_vld_reg    <= out_vld_next;
        end
    end

    always_ff @(posedge clk)
    begin
        out_x_reg    <= out_x_next;
        out_y_reg    <= out_y_next;
        out_last_reg <= out_last_next;
    end

    assign res_vld  = out_vld_reg;
    assign res_x    = out_x_reg;
    assign res_y    = out_y_reg;
    assign res_last = out_last_reg;

    // a load always leaves a line in progress
    a_load_activates: assert property (@(posedge clk) disable iff (!rst_n)
        do_load |=> active_reg)
        else $error("load did not activate line");

    // the final pixel ends the line
    a_last_ends_line: assert property (@(posedge clk) disable iff (!rst_n)
        (do_pixel && at_end) |=> (!active_reg && out_last_reg))
        else $error("final pixel left line active");

    // the major coordinate never runs past its end
    a_major_bound: assert property (@(posedge clk) disable iff (!rst_n)
        active_reg |-> (major_pos_reg <= major_end_reg))
        else $error("major coordinate past end");

    // a fresh result only follows a step taken on an active line
    a_result_source: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(out_vld_reg) |-> $past(do_pixel))
        else $error("result without a pixel step");

endmodule
